@@ rtl/afr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package afr_pkg;

    // Operation codes carried in a request.
    localparam logic OP_RECEIVE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    localparam logic [7:0] REPLY_GOOD = 8'h80;
    localparam logic [7:0] REPLY_BAD  = 8'h81;
    localparam logic [7:0] END_BYTE   = 8'h0A;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
        logic       ninth_bit;
    } item_t;

    typedef struct packed {
        logic       reply_valid;
        logic [7:0] reply_byte;
        logic [7:0] read_byte;
        logic       read_empty;
    } result_t;

    typedef struct packed {
        logic       en;
        logic [7:0] data;
    } fifo_wr_t;

endpackage

`default_nettype wire

@@ rtl/addressed_frame_receiver_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// item      input      item_valid / item_ready    item_t   (operation, rx_byte, ninth_bit)
// result    output     result_valid / result_ready result_t (reply, read byte, empty flag)
// cfg       input      cfg_write_en               own_address byte
//
// A request is held in the input register and its result is written to the result
// register when it advances; one request is accepted every cycle unless the result stalls.
// The FIFO memory read is registered, so read data is ready together with the result.
// A stalled result holds the pipeline; the input register keeps taking requests while
// it is free. Reset clears the frame state, pointers and valid flags at once.

module addressed_frame_receiver_core
    import afr_pkg::*;
#(
    parameter int FIFO_DEPTH = 64
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_ready,
    input  wire item_t      item,
    output logic            result_valid,
    input  wire logic       result_ready,
    output result_t         result,
    input  wire logic       cfg_write_en,
    input  wire logic [7:0] cfg_write_data
);

    logic [7:0] own_addr_reg;
    logic       s1_valid_reg;
    item_t      s1_item_reg;
    logic       advance;
    logic       rd_req;
    logic       fifo_empty;
    logic [7:0] fifo_read_byte;
    fifo_wr_t   fifo_wr;
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       reply_valid_reg;
    logic [7:0] reply_byte_reg;
    logic       read_empty_reg;

    assign advance    = s1_valid_reg && (!result_valid || result_ready);
    assign item_ready = !s1_valid_reg || advance;
    assign rd_req     = advance && (s1_item_reg.operation == OP_READ);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg <= 8'h00;
        end
        else if (cfg_write_en)
        begin
            own_addr_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                s1_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            s1_item_reg <= item;
        end
        if (advance)
        begin
            reply_valid_reg <= reply_valid;
            reply_byte_reg  <= reply_byte;
            read_empty_reg  <= rd_req && fifo_empty;
        end
    end

    afr_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .item        (s1_item_reg),
        .own_address (own_addr_reg),
        .fifo_wr     (fifo_wr),
        .reply_valid (reply_valid),
        .reply_byte  (reply_byte)
    );

    afr_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .fifo_wr   (fifo_wr),
        .rd_req    (rd_req),
        .empty     (fifo_empty),
        .read_byte (fifo_read_byte)
    );

    assign result.reply_valid = reply_valid_reg;
    assign result.reply_byte  = reply_byte_reg;
    assign result.read_byte   = fifo_read_byte;
    assign result.read_empty  = read_empty_reg;

endmodule

`default_nettype wire

@@ rtl/afr_frame.sv @@
`timescale 1ns / 1ps
`default_nettype none

module afr_frame
    import afr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire item_t      item,
    input  wire logic [7:0] own_address,
    output fifo_wr_t        fifo_wr,
    output logic            reply_valid,
    output logic [7:0]      reply_byte
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_SUM  = 2'd2;

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic       rx_step;

    assign rx_step = step && (item.operation == OP_RECEIVE);

    always_comb
    begin
        phase_next   = phase_reg;
        sum_next     = sum_reg;
        fifo_wr.en   = 1'b0;
        fifo_wr.data = item.rx_byte;
        reply_valid  = 1'b0;
        reply_byte   = 8'h00;
        if (rx_step)
        begin
            case (phase_reg)
                PH_SUM:
                begin
                    reply_valid = 1'b1;
                    reply_byte  = (item.rx_byte == {1'b0, sum_reg[6:0]}) ? REPLY_GOOD
                                                                          : REPLY_BAD;
                    phase_next  = PH_IDLE;
                end
                PH_DATA:
                begin
                    sum_next   = sum_reg + item.rx_byte;
                    fifo_wr.en = 1'b1;
                    if (item.rx_byte == END_BYTE)
                    begin
                        phase_next = PH_SUM;
                    end
                end
                default:
                begin
                    // The unused phase code behaves like idle.
                    if (item.ninth_bit && (item.rx_byte == own_address))
                    begin
                        phase_next = PH_DATA;
                        sum_next   = 8'h00;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            sum_reg   <= 8'h00;
        end
        else
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
        end
    end

    a_write_only_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_wr.en |-> (phase_reg == PH_DATA))
        else $error("FIFO write outside a frame");

    a_reply_closes_frame: assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid |=> (phase_reg == PH_IDLE))
        else $error("phase did not return to idle after a reply");

endmodule

`default_nettype wire

@@ rtl/afr_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module afr_fifo
    import afr_pkg::*;
#(
    parameter int FIFO_DEPTH = 64
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     step,
    input  wire fifo_wr_t fifo_wr,
    input  wire logic     rd_req,
    output logic          empty,
    output logic [7:0]    read_byte
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(FIFO_DEPTH - 1);

    logic [7:0]       mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic             entry0_written_reg;
    logic             hit_reg;
    logic             zero_reg;
    logic [7:0]       data_reg;
    logic             rd_take;

    assign wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign empty       = (wr_ptr_reg == rd_ptr_reg);
    assign rd_take     = rd_req && !empty;

    always_ff @(posedge clk)
    begin
        if (fifo_wr.en)
        begin
            mem[wr_ptr_next] <= fifo_wr.data;
        end
        if (rd_take)
        begin
            data_reg <= mem[rd_ptr_next];
        end
    end

    // Entry 0 reads as zero until its first write; the other entries have no reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg         <= '0;
            rd_ptr_reg         <= LAST;
            entry0_written_reg <= 1'b0;
            hit_reg            <= 1'b0;
            zero_reg           <= 1'b0;
        end
        else
        begin
            if (fifo_wr.en)
            begin
                wr_ptr_reg <= wr_ptr_next;
                if (wr_ptr_next == '0)
                begin
                    entry0_written_reg <= 1'b1;
                end
            end
            if (rd_take)
            begin
                rd_ptr_reg <= rd_ptr_next;
                zero_reg   <= (rd_ptr_next == '0) && !entry0_written_reg;
            end
            if (step)
            begin
                hit_reg <= rd_take;
            end
        end
    end

    assign read_byte = (hit_reg && !zero_reg) ? data_reg : 8'h00;

    a_no_read_and_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(fifo_wr.en && rd_req))
        else $error("FIFO read and write in the same cycle");

    a_read_advances: assert property (@(posedge clk) disable iff (!rst_n)
        rd_take |=> (rd_ptr_reg != $past(rd_ptr_reg)))
        else $error("read pointer did not advance on a read");

endmodule

`default_nettype wire
